FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands clocked on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

FILE: hdl/ils_pkg.sv
// ----------------------------------------------------------------------------
// ils_pkg
// types and constants shared by the indexed list store
// ----------------------------------------------------------------------------
package ils_pkg;

  localparam int KIND_W     = 3;
  localparam int POS_W      = 11;
  localparam int DATA_W     = 32;
  localparam int CELL_POS_W = 16;

  localparam logic signed [DATA_W-1:0] NOT_READ = -32'sd1;

  typedef enum logic [KIND_W-1:0] {
    KIND_READ        = 3'd0,
    KIND_INSERT_AT   = 3'd1,
    KIND_INSERT_HEAD = 3'd2,
    KIND_INSERT_TAIL = 3'd3,
    KIND_DELETE      = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE
  } cell_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_DONE
  } state_t;

  typedef struct packed {
    cell_op_t                op;
    logic [CELL_POS_W-1:0]   pos;
    logic [DATA_W-1:0]       value;
  } cell_ctrl_t;

endpackage

FILE: hdl/ils_ifs.sv
// ----------------------------------------------------------------------------
// ils_ifs
// request and result channels of the indexed list store
// ----------------------------------------------------------------------------
interface ils_in_if;
  import ils_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output kind, output position, output value, input ready);
  modport sink   (input valid, input kind, input position, input value, output ready);
endinterface

interface ils_out_if;
  import ils_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] read_value;
  logic                     accepted;
  logic [POS_W-1:0]         element_count;

  modport source (output valid, output read_value, output accepted, output element_count,
                  input ready);
  modport sink   (input valid, input read_value, input accepted, input element_count,
                  output ready);
endinterface

FILE: hdl/indexed_list_store_top.sv
// Indexed list store: an ordered list of up to CAPACITY signed 32-bit values held in a row
// of cells, one element per cell. Insert and delete shift every cell at or above the index
// at once, so a write request (insert at index, head or tail, or delete) goes through the
// execute and done states and its result beat is registered as it leaves done.
// A read travels down the registered read chain one cell per clock, so a read goes through
// the execute state, then waits in the read state until the chain has covered every cell.
// One request is in work at a time; a new request is taken while
// the previous result still waits in the output register, and a finished request waits,
// with the input stalled, until that register is free. Every request gives one result beat
// with the value read (-1 if none), an accepted flag and the new element count.
// ----------------------------------------------------------------------------
// indexed_list_store_top
// cell row of list elements with its request sequencer
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module indexed_list_store_top #(
  parameter int CAPACITY = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  ils_in_if.sink    in_ch,
  ils_out_if.source out_ch
);
  import ils_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  cell_ctrl_t        cell_ctrl;
  logic [CW-1:0]     count;
  logic [CW-1:0]     count_up;
  logic [CW-1:0]     count_dn;
  logic [DATA_W-1:0] elem_w [CAPACITY];
  logic [DATA_W-1:0] rd_w   [CAPACITY];

  ils_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cell_ctrl (cell_ctrl),
    .rd_last   (rd_w[CAPACITY-1]),
    .count     (count)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left_w;
    logic [DATA_W-1:0] right_w;
    logic [DATA_W-1:0] rd_in_w;

    if (i == 0) begin : g_first
      assign left_w  = cell_ctrl.value;
      assign rd_in_w = NOT_READ;
    end else begin : g_mid
      assign left_w  = elem_w[i-1];
      assign rd_in_w = rd_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_inner
      assign right_w = elem_w[i+1];
    end

    ils_cell #(
      .IDX (i)
    ) u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl),
      .left_elem  (left_w),
      .right_elem (right_w),
      .rd_in      (rd_in_w),
      .elem_o     (elem_w[i]),
      .rd_o       (rd_w[i])
    );
  end

  assign count_up = count + CW'(1);
  assign count_dn = count - CW'(1);

  `ASSERT_IMP(a_count_cap, 1'b1, count <= CW'(CAPACITY))
  `ASSERT_IMP(a_count_step, count != $past(count), count == $past(count_up) || count == $past(count_dn))
  `ASSERT_NXT(a_one_in_flight, in_ch.valid && in_ch.ready, !in_ch.ready)
  `ASSERT_IMP(a_reject_no_value, out_ch.valid && !out_ch.accepted, out_ch.read_value == NOT_READ)

endmodule

FILE: hdl/ils_cell.sv
// ----------------------------------------------------------------------------
// ils_cell
// one element slot: shifts with its neighbors and forwards the read chain
// ----------------------------------------------------------------------------
module ils_cell #(
  parameter int IDX = 0
) (
  input  logic                       clk,
  input  ils_pkg::cell_ctrl_t        ctrl,
  input  logic [ils_pkg::DATA_W-1:0] left_elem,
  input  logic [ils_pkg::DATA_W-1:0] right_elem,
  input  logic [ils_pkg::DATA_W-1:0] rd_in,
  output logic [ils_pkg::DATA_W-1:0] elem_o,
  output logic [ils_pkg::DATA_W-1:0] rd_o
);
  import ils_pkg::*;

  localparam logic [CELL_POS_W-1:0] IDX_V = CELL_POS_W'(IDX);

  logic [DATA_W-1:0] elem_r;
  logic [DATA_W-1:0] elem_nxt;
  logic [DATA_W-1:0] rd_r;
  logic [DATA_W-1:0] rd_nxt;
  logic              hit;
  logic              above;

  assign hit   = (IDX_V == ctrl.pos);
  assign above = (IDX_V > ctrl.pos);

  always_comb begin
    elem_nxt = elem_r;
    unique case (ctrl.op)
      CELL_INSERT: begin
        if (above) begin
          elem_nxt = left_elem;
        end else if (hit) begin
          elem_nxt = ctrl.value;
        end
      end
      CELL_DELETE: begin
        if (above || hit) begin
          elem_nxt = right_elem;
        end
      end
      default: begin
        elem_nxt = elem_r;
      end
    endcase
    rd_nxt = hit ? elem_r : rd_in;
  end

  always_ff @(posedge clk) begin
    elem_r <= elem_nxt;
    rd_r   <= rd_nxt;
  end

  assign elem_o = elem_r;
  assign rd_o   = rd_r;

endmodule

FILE: hdl/ils_ctrl.sv
// ----------------------------------------------------------------------------
// ils_ctrl
// request sequencer: decodes a beat, drives the cell row, builds the result
// ----------------------------------------------------------------------------
module ils_ctrl #(
  parameter int CAPACITY = 1024
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  ils_in_if.sink                                in_ch,
  ils_out_if.source                             out_ch,
  output ils_pkg::cell_ctrl_t                   cell_ctrl,
  input  logic [ils_pkg::DATA_W-1:0]            rd_last,
  output logic [$clog2(CAPACITY+1)-1:0]         count
);
  import ils_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CW-1:0] CAP_V = CW'(CAPACITY);

  state_t                   state_r, state_nxt;
  logic [CW-1:0]            cnt_r, cnt_nxt;
  logic [CW-1:0]            count_r, count_nxt;
  logic [KIND_W-1:0]        kind_r, kind_nxt;
  logic [POS_W-1:0]         pos_r, pos_nxt;
  logic [DATA_W-1:0]        value_r, value_nxt;
  logic [DATA_W-1:0]        res_rd_r, res_rd_nxt;
  logic                     res_ok_r, res_ok_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]        out_rd_r, out_rd_nxt;
  logic                     out_ok_r, out_ok_nxt;
  logic [POS_W-1:0]         out_cnt_r, out_cnt_nxt;

  logic [EW-1:0]            pos_ext;
  logic [EW-1:0]            cnt_ext;
  logic [EW-1:0]            pos_eff;
  logic                     not_full;
  logic                     op_ok;
  cell_op_t                 wr_op;

  // decode of the held request
  always_comb begin
    pos_ext  = EW'(pos_r);
    cnt_ext  = EW'(count_r);
    not_full = (count_r < CAP_V);
    pos_eff  = pos_ext;
    op_ok    = 1'b0;
    wr_op    = CELL_HOLD;
    unique case (kind_t'(kind_r))
      KIND_READ: begin
        op_ok = (pos_ext < cnt_ext);
      end
      KIND_INSERT_AT: begin
        op_ok = not_full && (pos_ext <= cnt_ext);
        wr_op = CELL_INSERT;
      end
      KIND_INSERT_HEAD: begin
        pos_eff = '0;
        op_ok   = not_full;
        wr_op   = CELL_INSERT;
      end
      KIND_INSERT_TAIL: begin
        pos_eff = cnt_ext;
        op_ok   = not_full;
        wr_op   = CELL_INSERT;
      end
      KIND_DELETE: begin
        op_ok = (pos_ext < cnt_ext);
        wr_op = CELL_DELETE;
      end
      default: begin
        op_ok = 1'b0;
        wr_op = CELL_HOLD;
      end
    endcase
  end

  assign cell_ctrl.op    = (state_r == ST_EXEC && op_ok) ? wr_op : CELL_HOLD;
  assign cell_ctrl.pos   = CELL_POS_W'(pos_eff);
  assign cell_ctrl.value = value_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    count_nxt     = count_r;
    kind_nxt      = kind_r;
    pos_nxt       = pos_r;
    value_nxt     = value_r;
    res_rd_nxt    = res_rd_r;
    res_ok_nxt    = res_ok_r;
    out_rd_nxt    = out_rd_r;
    out_ok_nxt    = out_ok_r;
    out_cnt_nxt   = out_cnt_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    in_ch.ready   = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          kind_nxt  = in_ch.kind;
          pos_nxt   = in_ch.position;
          value_nxt = in_ch.value;
          cnt_nxt   = '0;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cnt_nxt = cnt_r + CW'(1);
        if (kind_t'(kind_r) == KIND_READ) begin
          state_nxt = ST_READ;
        end else begin
          res_rd_nxt = NOT_READ;
          res_ok_nxt = op_ok;
          if (op_ok && wr_op == CELL_INSERT) begin
            count_nxt = count_r + CW'(1);
          end else if (op_ok && wr_op == CELL_DELETE) begin
            count_nxt = count_r - CW'(1);
          end
          state_nxt = ST_DONE;
        end
      end
      ST_READ: begin
        // read chain settles once a beat has rippled through every cell
        if (cnt_r == CAP_V) begin
          res_rd_nxt = op_ok ? rd_last : NOT_READ;
          res_ok_nxt = op_ok;
          state_nxt  = ST_DONE;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_rd_nxt    = res_rd_r;
          out_ok_nxt    = res_ok_r;
          out_cnt_nxt   = POS_W'(count_r);
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r    <= kind_nxt;
    pos_r     <= pos_nxt;
    value_r   <= value_nxt;
    res_rd_r  <= res_rd_nxt;
    res_ok_r  <= res_ok_nxt;
    out_rd_r  <= out_rd_nxt;
    out_ok_r  <= out_ok_nxt;
    out_cnt_r <= out_cnt_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.read_value    = out_rd_r;
  assign out_ch.accepted      = out_ok_r;
  assign out_ch.element_count = out_cnt_r;
  assign count                = count_r;

endmodule

FILE: verif/indexed_list_store_top_tb.sv
// ----------------------------------------------------------------------------
// indexed_list_store_top_tb
// self-checking bench for the indexed list store: a directed table covering
// empty, out-of-range, extreme-value and unknown-kind requests, then random
// traffic that fills the list to capacity, works it at full, then leans on
// deletes, each beat checked against typed table values or an in-bench model
// ----------------------------------------------------------------------------
module indexed_list_store_top_tb;
  import ils_pkg::*;

  localparam int CAPACITY = 1024;

  localparam logic [KIND_W-1:0] KIND_RSVD_A = 3'd5;
  localparam logic [KIND_W-1:0] KIND_RSVD_B = 3'd6;
  localparam logic [KIND_W-1:0] KIND_RSVD_C = 3'd7;

  localparam logic signed [DATA_W-1:0] MIN_VAL = 32'h8000_0000;
  localparam logic signed [DATA_W-1:0] MAX_VAL = 32'h7fff_ffff;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic                     accepted;
    logic [POS_W-1:0]         element_count;
  } outcome_t;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
    logic                     typed;
    logic signed [DATA_W-1:0] exp_read;
    logic                     exp_acc;
    logic [POS_W-1:0]         exp_count;
  } step_row_t;

  localparam int NUM_STEPS = 24;

  step_row_t directed_steps [NUM_STEPS] = '{
    '{KIND_READ,        11'd0,    32'sd0,     1'b1, NOT_READ, 1'b0, 11'd0},
    '{KIND_DELETE,      11'd0,    32'sd0,     1'b1, NOT_READ, 1'b0, 11'd0},
    '{KIND_INSERT_AT,   11'd1,    32'sd5,     1'b1, NOT_READ, 1'b0, 11'd0},
    '{KIND_INSERT_AT,   11'd0,    MAX_VAL,    1'b1, NOT_READ, 1'b1, 11'd1},
    '{KIND_INSERT_HEAD, 11'd2047, MIN_VAL,    1'b1, NOT_READ, 1'b1, 11'd2},
    '{KIND_INSERT_TAIL, 11'd2047, 32'sd0,     1'b1, NOT_READ, 1'b1, 11'd3},
    '{KIND_READ,        11'd0,    32'sd0,     1'b1, MIN_VAL,  1'b1, 11'd3},
    '{KIND_READ,        11'd2,    32'sd0,     1'b1, 32'sd0,   1'b1, 11'd3},
    '{KIND_READ,        11'd3,    32'sd0,     1'b1, NOT_READ, 1'b0, 11'd3},
    '{KIND_READ,        11'd2047, 32'sd0,     1'b1, NOT_READ, 1'b0, 11'd3},
    '{KIND_INSERT_AT,   11'd2047, 32'sd9,     1'b1, NOT_READ, 1'b0, 11'd3},
    '{KIND_INSERT_AT,   11'd3,    NOT_READ,   1'b1, NOT_READ, 1'b1, 11'd4},
    '{KIND_READ,        11'd3,    32'sd0,     1'b1, NOT_READ, 1'b1, 11'd4},
    '{KIND_RSVD_A,      11'd0,    MAX_VAL,    1'b1, NOT_READ, 1'b0, 11'd4},
    '{KIND_RSVD_B,      11'd0,    MAX_VAL,    1'b1, NOT_READ, 1'b0, 11'd4},
    '{KIND_RSVD_C,      11'd2047, MIN_VAL,    1'b1, NOT_READ, 1'b0, 11'd4},
    '{KIND_DELETE,      11'd4,    32'sd0,     1'b1, NOT_READ, 1'b0, 11'd4},
    '{KIND_DELETE,      11'd0,    32'sd0,     1'b1, NOT_READ, 1'b1, 11'd3},
    '{KIND_READ,        11'd0,    32'sd0,     1'b1, MAX_VAL,  1'b1, 11'd3},
    '{KIND_INSERT_AT,   11'd1,    32'h12345678, 1'b0, 32'sd0, 1'b0, 11'd0},
    '{KIND_READ,        11'd1,    32'sd0,     1'b0, 32'sd0,   1'b0, 11'd0},
    '{KIND_DELETE,      11'd3,    32'sd0,     1'b1, NOT_READ, 1'b1, 11'd3},
    '{KIND_DELETE,      11'd1024, 32'sd0,     1'b1, NOT_READ, 1'b0, 11'd3},
    '{KIND_READ,        11'd1024, 32'sd0,     1'b1, NOT_READ, 1'b0, 11'd3}
  };

  logic clk;
  logic rst_n;

  ils_in_if  in_ch ();
  ils_out_if out_ch ();

  indexed_list_store_top #(
    .CAPACITY(CAPACITY)
  ) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // list model
  logic signed [DATA_W-1:0] list_mem [CAPACITY];
  int unsigned              list_len = 0;

  outcome_t awaited_outcomes [$];

  int  failures        = 0;
  int  requests_sent   = 0;
  int  reads_sent      = 0;
  int  accepted_seen   = 0;
  int  peak_len        = 0;
  bit  steady_stream   = 1'b0;
  bit  hold_off_wanted = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(64'd48_000_000);
    $display("indexed_list_store_top verification failed");
    $finish;
  end

  function automatic bit list_insert(int unsigned at, logic signed [DATA_W-1:0] val);
    if (list_len >= CAPACITY || at > list_len) return 1'b0;
    for (int unsigned i = list_len; i > at; i--) list_mem[i] = list_mem[i-1];
    list_mem[at] = val;
    list_len++;
    return 1'b1;
  endfunction

  function automatic outcome_t list_apply(logic [KIND_W-1:0] op, logic [POS_W-1:0] pos,
                                          logic signed [DATA_W-1:0] val);
    outcome_t    res;
    int unsigned at;
    res.read_value = NOT_READ;
    res.accepted   = 1'b0;
    at             = pos;
    case (op)
      KIND_READ: begin
        if (at < list_len) begin
          res.read_value = list_mem[at];
          res.accepted   = 1'b1;
        end
      end
      KIND_INSERT_AT:   res.accepted = list_insert(at, val);
      KIND_INSERT_HEAD: res.accepted = list_insert(0, val);
      KIND_INSERT_TAIL: res.accepted = list_insert(list_len, val);
      KIND_DELETE: begin
        if (at < list_len) begin
          for (int unsigned i = at; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
          res.accepted = 1'b1;
        end
      end
      default: ;
    endcase
    res.element_count = POS_W'(list_len);
    return res;
  endfunction

  task automatic send_request(input logic [KIND_W-1:0] op, input logic [POS_W-1:0] pos,
                              input logic signed [DATA_W-1:0] val, input bit typed,
                              input outcome_t typed_res);
    outcome_t predicted;
    if (!steady_stream && $urandom_range(99) < 9) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.kind     <= op;
    in_ch.position <= pos;
    in_ch.value    <= val;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predicted = list_apply(op, pos, val);
    awaited_outcomes.push_back(typed ? typed_res : predicted);
    requests_sent++;
    if (op == KIND_READ) reads_sent++;
    if (list_len > peak_len) peak_len = list_len;
  endtask

  // weights in percent, remainder goes to unknown kinds
  task automatic send_random(input int w_rd, input int w_at, input int w_hd, input int w_tl,
                             input int w_del, input int in_range_pct);
    int                       roll;
    int                       top;
    logic [KIND_W-1:0]        op;
    logic [POS_W-1:0]         pos;
    logic signed [DATA_W-1:0] val;
    outcome_t                 no_typed;
    no_typed = '0;
    roll     = $urandom_range(99);
    if (roll < w_rd) op = KIND_READ;
    else if (roll < w_rd + w_at) op = KIND_INSERT_AT;
    else if (roll < w_rd + w_at + w_hd) op = KIND_INSERT_HEAD;
    else if (roll < w_rd + w_at + w_hd + w_tl) op = KIND_INSERT_TAIL;
    else if (roll < w_rd + w_at + w_hd + w_tl + w_del) op = KIND_DELETE;
    else op = KIND_W'($urandom_range(KIND_RSVD_C, KIND_RSVD_A));
    top = (op == KIND_INSERT_AT) ? int'(list_len) : int'(list_len) - 1;
    if (top >= 0 && $urandom_range(99) < in_range_pct) pos = POS_W'($urandom_range(top, 0));
    else pos = POS_W'($urandom());
    case ($urandom_range(9))
      0:       val = MIN_VAL;
      1:       val = MAX_VAL;
      2:       val = NOT_READ;
      default: val = $urandom();
    endcase
    send_request(op, pos, val, 1'b0, no_typed);
  endtask

  initial begin : request_source
    outcome_t typed_res;
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.kind     <= KIND_READ;
    in_ch.position <= '0;
    in_ch.value    <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_steps[i]) begin
      typed_res = '{directed_steps[i].exp_read, directed_steps[i].exp_acc,
                    directed_steps[i].exp_count};
      send_request(directed_steps[i].kind, directed_steps[i].position, directed_steps[i].value,
                   directed_steps[i].typed, typed_res);
    end

    repeat (80) send_random(25, 20, 10, 10, 30, 80);

    // fill up to capacity, with a stretch of back-to-back beats in the middle
    while (list_len < CAPACITY) begin
      steady_stream = (list_len >= 300 && list_len < 700);
      send_random(2, 30, 30, 34, 2, 95);
    end
    steady_stream = 1'b0;

    // at full: result side holds off while requests keep coming
    hold_off_wanted = 1'b1;
    repeat (40) send_random(20, 25, 10, 15, 20, 85);

    repeat (40) send_random(20, 10, 5, 5, 55, 80);

    in_ch.valid <= 1'b0;
    while (awaited_outcomes.size() != 0) @(posedge clk);
    repeat (CAPACITY + 8) @(posedge clk);

    $display("ran %0d requests (%0d reads), %0d accepted, list peaked at %0d of %0d elements",
             requests_sent, reads_sent, accepted_seen, peak_len, CAPACITY);
    if (failures == 0) begin
      $display("indexed_list_store_top verification clean");
    end else begin
      $display("indexed_list_store_top verification failed");
    end
    $finish;
  end

  initial begin : result_sink
    int       stall_left;
    bit       hold_off_done;
    outcome_t want;
    stall_left    = 0;
    hold_off_done = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        if (awaited_outcomes.size() == 0) begin
          $error("unexpected result beat: read_value %0d accepted %0b element_count %0d",
                 out_ch.read_value, out_ch.accepted, out_ch.element_count);
          failures++;
        end else begin
          want = awaited_outcomes.pop_front();
          if (out_ch.accepted === 1'b1) accepted_seen++;
          if (out_ch.read_value !== want.read_value) begin
            $error("read_value: expected %0d, actual %0d", want.read_value, out_ch.read_value);
            failures++;
          end
          if (out_ch.accepted !== want.accepted) begin
            $error("accepted: expected %0b, actual %0b", want.accepted, out_ch.accepted);
            failures++;
          end
          if (out_ch.element_count !== want.element_count) begin
            $error("element_count: expected %0d, actual %0d", want.element_count,
                   out_ch.element_count);
            failures++;
          end
        end
      end
      if (hold_off_wanted && !hold_off_done) begin
        stall_left    = 400;
        hold_off_done = 1'b1;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= steady_stream || ($urandom_range(99) >= 9);
      end
    end
  end

endmodule
